// ===== rtl/ipf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ipf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned LIMIT_W = 16;

  localparam logic [BYTE_W-1:0]  SYNC_0      = 8'h55;
  localparam logic [BYTE_W-1:0]  SYNC_1      = 8'haa;
  localparam logic [BYTE_W-1:0]  SYNC_2      = 8'h20;
  localparam logic [BYTE_W-1:0]  SUM_SEED    = 8'h20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd65000;

  // control from the framer sequencer to the running-sum unit
  typedef struct packed {
    logic init;   // load both sums with the seed
    logic upd;    // fold the current byte into the sums
  } sum_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ipf_fletcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ipf_fletcher
  import ipf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sum_ctl_t          ctl,
  input  wire logic [BYTE_W-1:0] din,
  output logic      [BYTE_W-1:0] sum_lo,
  output logic      [BYTE_W-1:0] sum_hi
);

  logic [BYTE_W-1:0] lo_r, lo_nxt;
  logic [BYTE_W-1:0] hi_r, hi_nxt;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (ctl.init) begin
      lo_nxt = SUM_SEED;
      hi_nxt = SUM_SEED;
    end else if (ctl.upd) begin
      lo_nxt = lo_r + din;
      hi_nxt = hi_r + lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= SUM_SEED;
      hi_r <= SUM_SEED;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign sum_lo = lo_r;
  assign sum_hi = hi_r;

endmodule
`default_nettype wire

// ===== rtl/image_packetizer_fletcher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one image byte per cycle inside a packet while out_tready is high; each
//   packet boundary adds the two sum bytes plus the next header to the output, and an
//   opening item emits a header (followed by the sums when the image is empty).
//   The single output byte register sets the rate: one result per cycle while not stalled.
// Reset: rst_n synchronous, active low; clears all framing state, limit to 65000.
module image_packetizer_fletcher_core
  import ipf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,    // payload_limit
  // image input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // [7:0] data_byte, [31:8] image_length
  // framed output
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,   // [7:0] out_byte
  output logic             out_tlast,   // packet_end
  output logic             out_tuser    // [0] run_last
);

  localparam logic [3:0] ST_START = 4'd0;
  localparam logic [3:0] ST_H0    = 4'd1;
  localparam logic [3:0] ST_H1    = 4'd2;
  localparam logic [3:0] ST_H2    = 4'd3;
  localparam logic [3:0] ST_H3    = 4'd4;
  localparam logic [3:0] ST_H4    = 4'd5;
  localparam logic [3:0] ST_H5    = 4'd6;
  localparam logic [3:0] ST_H6    = 4'd7;
  localparam logic [3:0] ST_H7    = 4'd8;
  localparam logic [3:0] ST_H8    = 4'd9;
  localparam logic [3:0] ST_H9    = 4'd10;
  localparam logic [3:0] ST_SLO   = 4'd11;
  localparam logic [3:0] ST_SHI   = 4'd12;

  // config register
  logic [LIMIT_W-1:0] cfg_limit_r;

  // input register
  logic              item_v_r;
  logic [BYTE_W-1:0] item_byte_r;
  logic [LEN_W-1:0]  item_len_r;

  // framing state
  logic [3:0]         step_r, step_nxt;
  logic [4:0]         seq_r, seq_nxt;
  logic               active_r, active_nxt;
  logic               drop_r, drop_nxt;
  logic               full_r, full_nxt;
  logic               split_r, split_nxt;
  logic [LEN_W-1:0]   total_r, total_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [LIMIT_W-1:0] pkt_rem_r, pkt_rem_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [LIMIT_W-1:0] size_r, size_nxt;
  logic [3:0]         index_r, index_nxt;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_end_r;
  logic              out_last_r;

  logic              emit_ok, emit, emit_end, emit_last, item_done;
  logic [BYTE_W-1:0] emit_byte;
  sum_ctl_t          sctl;
  logic [BYTE_W-1:0] sum_lo, sum_hi;

  logic [LIMIT_W-1:0] lim_sel;
  logic [LEN_W-1:0]   nine_lim;
  logic [LIMIT_W-1:0] open_size, next_size;
  logic [BYTE_W-1:0]  flags;

  ipf_fletcher u_sum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sctl),
    .din    (emit_byte),
    .sum_lo (sum_lo),
    .sum_hi (sum_hi)
  );

  assign cfg_ready = 1'b1;
  assign emit_ok   = !out_valid_r || out_tready;
  assign in_tready = !item_v_r || item_done;

  // limit of zero behaves as one; drop when len / limit >= 9
  assign lim_sel   = (cfg_limit_r == '0) ? LIMIT_W'(1) : cfg_limit_r;
  assign nine_lim  = ({{(LEN_W-LIMIT_W){1'b0}}, lim_sel} << 3)
                   + {{(LEN_W-LIMIT_W){1'b0}}, lim_sel};
  assign open_size = (item_len_r < {{(LEN_W-LIMIT_W){1'b0}}, lim_sel})
                   ? item_len_r[LIMIT_W-1:0] : lim_sel;
  assign next_size = (rem_r < {{(LEN_W-LIMIT_W){1'b0}}, limit_r})
                   ? rem_r[LIMIT_W-1:0] : limit_r;
  assign flags     = split_r ? {1'b1, index_r[1:0], seq_r} : {3'b000, seq_r};

  always_comb begin
    step_nxt    = step_r;
    seq_nxt     = seq_r;
    active_nxt  = active_r;
    drop_nxt    = drop_r;
    full_nxt    = full_r;
    split_nxt   = split_r;
    total_nxt   = total_r;
    rem_nxt     = rem_r;
    pkt_rem_nxt = pkt_rem_r;
    limit_nxt   = limit_r;
    size_nxt    = size_r;
    index_nxt   = index_r;
    emit        = 1'b0;
    emit_byte   = '0;
    emit_end    = 1'b0;
    emit_last   = 1'b0;
    item_done   = 1'b0;
    sctl        = '0;

    unique case (step_r)
      ST_START: begin
        if (item_v_r) begin
          if (!active_r) begin
            seq_nxt   = (seq_r == 5'd31) ? 5'd1 : seq_r + 5'd1;
            limit_nxt = lim_sel;
            total_nxt = item_len_r;
            rem_nxt   = item_len_r;
            index_nxt = '0;
            split_nxt = item_len_r > {{(LEN_W-LIMIT_W){1'b0}}, lim_sel};
            size_nxt  = open_size;
            if (item_len_r >= nine_lim) begin
              drop_nxt    = 1'b1;
              active_nxt  = 1'b1;
              pkt_rem_nxt = '0;
              item_done   = 1'b1;
            end else begin
              drop_nxt = 1'b0;
              step_nxt = ST_H0;
            end
          end else if (drop_r) begin
            rem_nxt = rem_r - LEN_W'(1);
            if (rem_r == LEN_W'(1)) begin
              active_nxt = 1'b0;
              drop_nxt   = 1'b0;
            end
            item_done = 1'b1;
          end else if (emit_ok) begin
            emit        = 1'b1;
            emit_byte   = item_byte_r;
            sctl.upd    = 1'b1;
            rem_nxt     = rem_r - LEN_W'(1);
            pkt_rem_nxt = pkt_rem_r - LIMIT_W'(1);
            if (pkt_rem_r == LIMIT_W'(1)) begin
              step_nxt = ST_SLO;
            end else begin
              emit_last = 1'b1;
              item_done = 1'b1;
            end
          end
        end
      end
      ST_H0: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = SYNC_0;
        sctl.init = 1'b1;
        step_nxt  = ST_H1;
      end
      ST_H1: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = SYNC_1;
        step_nxt  = ST_H2;
      end
      ST_H2: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = SYNC_2;
        step_nxt  = ST_H3;
      end
      ST_H3: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = flags;
        sctl.upd  = 1'b1;
        step_nxt  = ST_H4;
      end
      ST_H4: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = total_r[7:0];
        sctl.upd  = 1'b1;
        step_nxt  = ST_H5;
      end
      ST_H5: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = total_r[15:8];
        sctl.upd  = 1'b1;
        step_nxt  = ST_H6;
      end
      ST_H6: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = total_r[23:16];
        sctl.upd  = 1'b1;
        step_nxt  = ST_H7;
      end
      ST_H7: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = size_r[7:0];
        sctl.upd  = 1'b1;
        step_nxt  = ST_H8;
      end
      ST_H8: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = size_r[15:8];
        sctl.upd  = 1'b1;
        step_nxt  = ST_H9;
      end
      ST_H9: if (emit_ok) begin
        // payload size never exceeds 16 bits, top size byte is zero
        emit        = 1'b1;
        emit_byte   = '0;
        sctl.upd    = 1'b1;
        pkt_rem_nxt = size_r;
        full_nxt    = (size_r == limit_r);
        active_nxt  = (size_r != '0);
        if (size_r == '0) begin
          step_nxt = ST_SLO;
        end else begin
          emit_last = 1'b1;
          item_done = 1'b1;
          step_nxt  = ST_START;
        end
      end
      ST_SLO: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = sum_lo;
        step_nxt  = ST_SHI;
      end
      ST_SHI: if (emit_ok) begin
        emit      = 1'b1;
        emit_byte = sum_hi;
        emit_end  = 1'b1;
        if (rem_r != '0 || full_r) begin
          index_nxt = index_r + 4'd1;
          size_nxt  = next_size;
          step_nxt  = ST_H0;
        end else begin
          active_nxt = 1'b0;
          full_nxt   = 1'b0;
          emit_last  = 1'b1;
          item_done  = 1'b1;
          step_nxt   = ST_START;
        end
      end
      default: step_nxt = ST_START;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      item_v_r <= 1'b1;
    end else if (item_done) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_byte_r <= in_tdata[7:0];
      item_len_r  <= in_tdata[31:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_START;
      seq_r     <= '0;
      active_r  <= 1'b0;
      drop_r    <= 1'b0;
      full_r    <= 1'b0;
      split_r   <= 1'b0;
      total_r   <= '0;
      rem_r     <= '0;
      pkt_rem_r <= '0;
      limit_r   <= LIMIT_RESET;
      size_r    <= '0;
      index_r   <= '0;
    end else begin
      step_r    <= step_nxt;
      seq_r     <= seq_nxt;
      active_r  <= active_nxt;
      drop_r    <= drop_nxt;
      full_r    <= full_nxt;
      split_r   <= split_nxt;
      total_r   <= total_nxt;
      rem_r     <= rem_nxt;
      pkt_rem_r <= pkt_rem_nxt;
      limit_r   <= limit_nxt;
      size_r    <= size_nxt;
      index_r   <= index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_end_r  <= emit_end;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/ipf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ipf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // results of one input transaction follow without gaps
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser |=> out_tvalid)
    else $error("gap inside a result run");

  // a packet that is not the last of its run is followed by the next header
  a_next_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast && !out_tuser
      |=> out_tvalid && out_tdata == 8'h55 && !out_tlast)
    else $error("missing header after packet end");

  // a run never ends on a header sync byte
  a_sync_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && $past(out_tvalid && out_tready && out_tlast && !out_tuser)
      |-> !out_tuser)
    else $error("run ended on a header sync byte");

endmodule

bind image_packetizer_fletcher_core ipf_checker u_ipf_checker (.*);
`default_nettype wire
